[design/umbrella_histogram_free_energy_core_macros.svh]
// Assertion macros shared by the histogram core checker.
`ifndef UMBRELLA_HISTOGRAM_FREE_ENERGY_CORE_MACROS_SVH
`define UMBRELLA_HISTOGRAM_FREE_ENERGY_CORE_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define UHFE_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uhfe assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define UHFE_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uhfe assertion failed");

`endif

[design/uhfe_pkg.sv]
// Package: shared constants, types and helpers of the histogram core.
`timescale 1ns / 1ps
`default_nettype none
package uhfe_pkg;

  localparam int NUM_BINS_DEF   = 64;
  localparam int COUNT_BITS_DEF = 32;
  localparam int FRAC_BITS      = 24;
  localparam int DIV_STEPS      = 32;
  localparam int REG_IDX_W      = 3;
  localparam int REG_DATA_W     = 32;

  localparam logic [23:0] LN2_Q24 = 24'd11629080;
  localparam logic [40:0] BIAS_CAP = 41'h100_0000_0000;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [30:0]        BIN_WIDTH_RST  = 31'd65536;
  localparam logic [30:0]        TEMP_RST       = 31'd65536;
  localparam logic [30:0]        SPRING_RST     = 31'd0;
  localparam logic signed [31:0] BIAS_CTR_RST   = 32'sd0;
  localparam logic signed [15:0] LOWEST_BIN_RST = -16'sd32;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BIN_WIDTH   = 3'd0,
    REG_TEMPERATURE = 3'd1,
    REG_SPRING      = 3'd2,
    REG_BIAS_CENTER = 3'd3,
    REG_LOWEST_BIN  = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_BIN, S_ADD_WR, S_LOG_W, S_LOG_T, S_SCAN, S_CNT_RD,
    S_LOG_C, S_LNQ, S_E1, S_BIAS, S_EMIT, S_CLEAR
  } st_t;

  typedef enum logic [1:0] {
    L_IDLE, L_NORM, L_SQ
  } lg_st_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

[design/uhfe_if.sv]
// Interfaces: sample input channel and result output channel.
`timescale 1ns / 1ps
`default_nettype none
interface uhfe_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] sample_value;

  modport source (output valid, output opcode, output sample_value, input ready);
  modport sink (input valid, input opcode, input sample_value, output ready);
endinterface

interface uhfe_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] bin_center;
  logic [31:0] free_energy;
  logic        last;
  logic        range_miss;

  modport source (output valid, output bin_center, output free_energy, output last,
                  output range_miss, input ready);
  modport sink (input valid, input bin_center, input free_energy, input last,
                input range_miss, output ready);
endinterface
`default_nettype wire

[design/uhfe_log2.sv]
// Iterative log2 unit: leading-one search, then 24 squaring steps (Q.24 result).
`timescale 1ns / 1ps
`default_nettype none
module uhfe_log2 #(
  parameter int LW = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [LW-1:0] x,
  output logic done,
  output logic [$clog2(LW)+uhfe_pkg::FRAC_BITS-1:0] res
);
  import uhfe_pkg::*;

  localparam int EB = $clog2(LW);
  localparam int CW = $clog2(FRAC_BITS);
  localparam logic [CW-1:0] CNT_LAST = CW'(FRAC_BITS - 1);

  lg_st_t state, state_next;
  logic [LW-1:0]        m;
  logic [EB-1:0]        e;
  logic [31:0]          mant;
  logic [FRAC_BITS-1:0] frac;
  logic [CW-1:0]        cnt;
  logic [63:0]          sq;
  logic [32:0]          sqs;

  assign sq  = 64'(mant) * 64'(mant);
  assign sqs = sq[63:31];
  assign res = {e, frac};

  always_comb begin
    state_next = state;
    unique case (state)
      L_IDLE: if (start) state_next = L_NORM;
      L_NORM: if (m[LW-1]) state_next = L_SQ;
      L_SQ:   if (cnt == CNT_LAST) state_next = L_IDLE;
      default: state_next = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == L_SQ) && (cnt == CNT_LAST);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      L_IDLE: if (start) begin
        m <= (x == '0) ? LW'(1) : x;
        e <= EB'(LW - 1);
      end
      L_NORM: begin
        if (m[LW-1]) begin
          mant <= m[LW-1 -: 32];
          frac <= '0;
          cnt  <= '0;
        end else begin
          m <= {m[LW-2:0], 1'b0};
          e <= e - EB'(1);
        end
      end
      L_SQ: begin
        // renormalize the square back into [1, 2)
        frac <= {frac[FRAC_BITS-2:0], sqs[32]};
        mant <= sqs[32] ? sqs[32:1] : sqs[31:0];
        cnt  <= cnt + CW'(1);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[design/umbrella_histogram_free_energy_core.sv]
// Top level: histogram of samples in a count memory, free energy per filled bin on finish.
//
//  channel   | dir | payload                                       | handshake
//  ----------+-----+-----------------------------------------------+-----------
//  samples   | in  | opcode, sample_value                          | valid/ready
//  results   | out | bin_center, free_energy, last, range_miss     | valid/ready
//  wr_*      | in  | wr_index, wr_data                             | wr_en only
//
// An add word runs 32 restoring divide steps to set the bin, then a read and a write
// of the count memory; both are skipped when the sample misses the window. A finish
// word runs two log2 runs, on the bin width and then on the total, then scans the
// slots: an empty slot is passed over, a filled slot goes through S_SCAN, S_CNT_RD,
// a log2 run, S_LNQ, S_E1, S_BIAS and S_EMIT; a clearing state ends it. Reset is
// synchronous; a per-slot valid bitmap stands for the cleared counts, so no clearing
// pass is run. A stalled result holds its output register and the walk waits on it.
`timescale 1ns / 1ps
`default_nettype none
module umbrella_histogram_free_energy_core #(
  parameter int NUM_BINS   = uhfe_pkg::NUM_BINS_DEF,
  parameter int COUNT_BITS = uhfe_pkg::COUNT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  uhfe_in_if.sink    samples,
  uhfe_out_if.source results,
  input  logic wr_en,
  input  logic [uhfe_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [uhfe_pkg::REG_DATA_W-1:0] wr_data
);
  import uhfe_pkg::*;

  localparam int SB = $clog2(NUM_BINS);
  localparam int LW = (COUNT_BITS > 32) ? COUNT_BITS : 32;
  localparam int EB = $clog2(LW);
  localparam int RW = EB + FRAC_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // configuration
  logic [30:0]        bin_width, temperature, spring_constant;
  logic signed [31:0] bias_center;
  logic signed [15:0] lowest_bin;
  logic [30:0]        weff;

  // control and histogram state
  st_t                   state, state_next;
  logic [SB:0]           s_idx;
  logic [SB-1:0]         s_cur, slot;
  logic [NUM_BINS-1:0]   bitmap;
  logic [COUNT_BITS-1:0] total;
  logic                  miss;

  // divider
  logic [31:0] quo, rem, r2;
  logic [5:0]  div_cnt;
  logic        neg, ge;
  logic [33:0] qs, bq, slot_calc;
  logic        in_range;

  // count memory
  logic [COUNT_BITS-1:0] mem [NUM_BINS];
  logic                  mem_re, mem_we;
  logic [SB-1:0]         mem_raddr, mem_waddr;
  logic [COUNT_BITS-1:0] mem_rdata, mem_wdata, cnt_cur;

  // log2 unit
  logic          log_start, log_done;
  logic [LW-1:0] log_x;
  logic [RW-1:0] log_res, l2w, l2t;

  // free energy datapath
  logic signed [16:0] bidx;
  logic signed [48:0] cprod;
  logic signed [49:0] center, center_calc;
  logic signed [50:0] cdelta;
  logic [50:0]        dist_abs;
  logic               dist_far;
  logic [31:0]        dist_lo;
  logic signed [32:0] lval, lval_calc, lnq;
  logic signed [57:0] lprod;
  logic [63:0]        dsq;
  logic signed [64:0] eprod;
  logic signed [40:0] e1;
  logic [62:0]        ka, kb;
  logic [63:0]        bsum;
  logic [40:0]        bias, bias_calc;
  logic signed [42:0] fe_full;
  logic               later, load_out;

  // output register
  logic        ovalid, o_last, o_miss;
  logic [31:0] o_center, o_fe;

  assign weff  = (bin_width == '0) ? 31'd1 : bin_width;
  assign s_cur = s_idx[SB-1:0];

  assign samples.ready       = (state == S_IDLE);
  assign results.valid       = ovalid;
  assign results.bin_center  = o_center;
  assign results.free_energy = o_fe;
  assign results.last        = o_last;
  assign results.range_miss  = o_miss;

  uhfe_log2 #(.LW(LW)) u_log2 (
    .clk   (clk),
    .rst   (rst),
    .start (log_start),
    .x     (log_x),
    .done  (log_done),
    .res   (log_res)
  );

  // divide step and bin placement
  always_comb begin
    r2 = {rem[30:0], quo[31]};
    ge = (r2 >= {1'b0, weff});
    qs = {2'b00, quo};
    // floor for negative samples: round the magnitude quotient away from zero
    bq = neg ? (~qs + 34'd1 - 34'(rem != '0)) : qs;
    slot_calc = bq - {{18{lowest_bin[15]}}, lowest_bin};
    in_range  = !slot_calc[33] && (slot_calc < 34'(NUM_BINS));
    cnt_cur   = bitmap[slot] ? mem_rdata : '0;
  end

  // per-slot arithmetic
  always_comb begin
    bidx        = $signed({lowest_bin[15], lowest_bin}) + $signed(17'(s_cur));
    cprod       = bidx * $signed({1'b0, weff});
    center_calc = {cprod[48], cprod} + 50'(weff >> 1);
    cdelta      = {center[49], center} - {{19{bias_center[31]}}, bias_center};
    dist_abs    = cdelta[50] ? 51'(-cdelta) : cdelta;
    lval_calc   = $signed(33'(l2t)) + $signed(33'(l2w))
                  - $signed(33'(16 << FRAC_BITS)) - $signed(33'(log_res));
    lprod       = lval * $signed({1'b0, LN2_Q24});
    eprod       = $signed({1'b0, temperature}) * lnq;
    bsum        = 64'(ka >> 1) + (({31'd0, ka[0], 32'd0} + 64'(kb)) >> 33);
    if (spring_constant == '0) bias_calc = '0;
    else if (dist_far || bsum > 64'(BIAS_CAP)) bias_calc = BIAS_CAP;
    else bias_calc = bsum[40:0];
    fe_full = {{2{e1[40]}}, e1} - $signed({2'b00, bias});
    later = 1'b0;
    for (int j = 0; j < NUM_BINS; j++) begin
      if (j > int'(s_cur) && bitmap[j]) later = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    mem_re     = 1'b0;
    mem_raddr  = s_cur;
    mem_we     = 1'b0;
    mem_waddr  = slot;
    mem_wdata  = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + COUNT_BITS'(1);
    log_start  = 1'b0;
    log_x      = LW'(weff);
    load_out   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (samples.valid) begin
          if (samples.opcode == OP_FINISH) begin
            log_start  = 1'b1;
            state_next = S_LOG_W;
          end else begin
            state_next = S_DIV;
          end
        end
      end
      S_DIV: if (div_cnt == 6'(DIV_STEPS - 1)) state_next = S_BIN;
      S_BIN: begin
        if (in_range) begin
          mem_re     = 1'b1;
          mem_raddr  = slot_calc[SB-1:0];
          state_next = S_ADD_WR;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_ADD_WR: begin
        mem_we     = 1'b1;
        state_next = S_IDLE;
      end
      S_LOG_W: begin
        if (log_done) begin
          log_start  = 1'b1;
          log_x      = LW'(total);
          state_next = S_LOG_T;
        end
      end
      S_LOG_T: if (log_done) state_next = S_SCAN;
      S_SCAN: begin
        if (s_idx == (SB+1)'(NUM_BINS)) begin
          state_next = S_CLEAR;
        end else if (bitmap[s_cur]) begin
          mem_re     = 1'b1;
          state_next = S_CNT_RD;
        end
      end
      S_CNT_RD: begin
        log_start  = 1'b1;
        log_x      = LW'(mem_rdata);
        state_next = S_LOG_C;
      end
      S_LOG_C: if (log_done) state_next = S_LNQ;
      S_LNQ:   state_next = S_E1;
      S_E1:    state_next = S_BIAS;
      S_BIAS:  state_next = S_EMIT;
      S_EMIT: begin
        // hold until the output register is free
        if (!ovalid || results.ready) begin
          load_out   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_CLEAR: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      bitmap          <= '0;
      total           <= '0;
      miss            <= 1'b0;
      bin_width       <= BIN_WIDTH_RST;
      temperature     <= TEMP_RST;
      spring_constant <= SPRING_RST;
      bias_center     <= BIAS_CTR_RST;
      lowest_bin      <= LOWEST_BIN_RST;
    end else begin
      state <= state_next;
      if (wr_en) begin
        unique case (wr_index)
          REG_BIN_WIDTH:   bin_width       <= wr_data[30:0];
          REG_TEMPERATURE: temperature     <= wr_data[30:0];
          REG_SPRING:      spring_constant <= wr_data[30:0];
          REG_BIAS_CENTER: bias_center     <= wr_data;
          REG_LOWEST_BIN:  lowest_bin      <= wr_data[15:0];
          default: ;
        endcase
      end
      if (state == S_BIN && !in_range) miss <= 1'b1;
      if (state == S_ADD_WR) begin
        bitmap[slot] <= 1'b1;
        if (total != CNT_MAX) total <= total + COUNT_BITS'(1);
      end
      if (state == S_CLEAR) begin
        bitmap <= '0;
        total  <= '0;
        miss   <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        neg     <= samples.sample_value[31];
        quo     <= samples.sample_value[31] ? (~samples.sample_value + 32'd1)
                                            : samples.sample_value;
        rem     <= '0;
        div_cnt <= '0;
        s_idx   <= '0;
      end
      S_DIV: begin
        rem     <= ge ? (r2 - {1'b0, weff}) : r2;
        quo     <= {quo[30:0], ge};
        div_cnt <= div_cnt + 6'd1;
      end
      S_BIN:   slot <= slot_calc[SB-1:0];
      S_LOG_W: if (log_done) l2w <= log_res;
      S_LOG_T: if (log_done) l2t <= log_res;
      S_SCAN: begin
        if (s_idx != (SB+1)'(NUM_BINS)) begin
          if (bitmap[s_cur]) center <= center_calc;
          else s_idx <= s_idx + (SB+1)'(1);
        end
      end
      S_CNT_RD: begin
        dist_far <= (dist_abs[50:32] != '0);
        dist_lo  <= dist_abs[31:0];
      end
      S_LOG_C: if (log_done) lval <= lval_calc;
      S_LNQ: begin
        lnq <= 33'((lprod + 58'sd8388608) >>> FRAC_BITS);
        dsq <= 64'(dist_lo) * 64'(dist_lo);
      end
      S_E1: begin
        e1 <= 41'((eprod + 65'sd8388608) >>> FRAC_BITS);
        ka <= 63'(spring_constant) * 63'(dsq[63:32]);
        kb <= 63'(spring_constant) * 63'(dsq[31:0]);
      end
      S_BIAS: bias <= bias_calc;
      S_EMIT: if (load_out) s_idx <= s_idx + (SB+1)'(1);
      default: ;
    endcase
  end

  // count memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata <= mem[mem_raddr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) ovalid <= 1'b0;
    else if (load_out) ovalid <= 1'b1;
    else if (results.ready) ovalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_center <= sat32(64'(center));
      o_fe     <= sat32(64'(fe_full));
      o_last   <= !later;
      o_miss   <= miss;
    end
  end

endmodule
`default_nettype wire

[design/uhfe_checker.sv]
// Port checker for the histogram core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "umbrella_histogram_free_energy_core_macros.svh"
module uhfe_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_opcode,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_last,
  input logic [31:0] out_fe
);
  import uhfe_pkg::*;

  `UHFE_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `UHFE_NEXT(a_fe_stable, clk, rst, out_valid && !out_ready, $stable(out_fe))
  `UHFE_NEXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready)
  `UHFE_NEXT(a_add_no_result, clk, rst,
             in_valid && in_ready && in_opcode == OP_ADD && !out_valid, !out_valid)
  `UHFE_SAME(a_idle_wait_is_last, clk, rst, in_ready && out_valid, out_last)

endmodule

bind umbrella_histogram_free_energy_core uhfe_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .in_opcode (samples.opcode),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_last  (results.last),
  .out_fe    (results.free_energy)
);
`default_nettype wire

[test/tb_top.sv]
// Testbench for the histogram free-energy core: random bursts of samples, checked per bin.
`timescale 1ns / 1ps
module tb_top;
  import uhfe_pkg::*;

  typedef struct packed {
    logic        opcode;
    logic [31:0] sample_value;
  } sample_word_t;

  typedef struct packed {
    logic [31:0] bin_center;
    logic [31:0] free_energy;
    logic        last;
    logic        range_miss;
  } bin_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [REG_IDX_W-1:0] wr_index = '0;
  logic [REG_DATA_W-1:0] wr_data = '0;

  uhfe_in_if  samples ();
  uhfe_out_if results ();

  umbrella_histogram_free_energy_core DUT (
    .clk(clk), .rst(rst), .samples(samples), .results(results),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the block: registers and histogram
  longint unsigned width_reg, temp_reg, spring_reg;
  longint          center_reg, low_bin_reg;
  longint unsigned hist [64];
  longint unsigned hist_total;
  bit              miss_seen;

  sample_word_t pend_q[$];
  bin_word_t    bins_q[$];
  int errors = 0;
  int n_adds = 0, n_outside = 0, n_finish = 0, n_bins = 0;

  function automatic longint sat_q16(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint log2_q24(longint unsigned x);
    int unsigned e;
    longint unsigned m, frac;
    e = 0;
    frac = 0;
    if (x == 0) x = 1;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    m = (e > 31) ? (x >> (e - 31)) : (x << (31 - e));
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac |= 1;
        m = m >> 1;
      end
    end
    return longint'((64'(e) << 24) | frac);
  endfunction

  function automatic longint umbrella_bias(longint delta);
    longint unsigned d, q, a, b;
    d = (delta < 0) ? unsigned'(-delta) : unsigned'(delta);
    if (spring_reg == 0) return 0;
    if (d >= 64'h1_0000_0000) return 64'sh100_0000_0000;
    q = d * d;
    a = spring_reg * (q >> 32);
    b = spring_reg * (q & 64'hFFFF_FFFF);
    q = (a >> 1) + ((((a & 1) << 32) + b) >> 33);
    return (q > 64'h100_0000_0000) ? 64'sh100_0000_0000 : longint'(q);
  endfunction

  function automatic longint eff_width();
    return (width_reg == 0) ? 1 : longint'(width_reg);
  endfunction

  task automatic bin_sample(input logic [31:0] raw);
    longint y, w, b, slot;
    y = longint'(signed'(raw));
    w = eff_width();
    b = y / w;
    if (y % w != 0 && y < 0) b--;
    slot = b - low_bin_reg;
    n_adds++;
    if (slot >= 0 && slot < 64) begin
      if (hist[slot] < 64'hFFFF_FFFF) hist[slot]++;
      if (hist_total < 64'hFFFF_FFFF) hist_total++;
    end else begin
      miss_seen = 1'b1;
      n_outside++;
    end
  endtask

  task automatic emit_free_energy();
    longint w, b, c, l, lnq, e1, f;
    bin_word_t r;
    int n;
    w = eff_width();
    n = 0;
    n_finish++;
    for (int s = 0; s < 64; s++) begin
      if (hist[s] != 0) begin
        b = low_bin_reg + s;
        c = b * w + w / 2;
        l = log2_q24(hist_total) + log2_q24(unsigned'(w)) - (64'sd16 << 24)
            - log2_q24(hist[s]);
        lnq = (l * longint'(LN2_Q24) + (64'sd1 << 23)) >>> 24;
        e1 = (longint'(temp_reg) * lnq + (64'sd1 << 23)) >>> 24;
        f = sat_q16(e1 - umbrella_bias(c - center_reg));
        r.bin_center = 32'(sat_q16(c));
        r.free_energy = 32'(f);
        r.last = 1'b0;
        r.range_miss = miss_seen;
        bins_q = {bins_q, r};
        n++;
      end
      hist[s] = 0;
    end
    if (n > 0) bins_q[$].last = 1'b1;
    hist_total = 0;
    miss_seen = 1'b0;
  endtask

  // sender: bursts with gaps
  logic took = 1'b0;
  int burst_left = 0, gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      samples.valid <= 1'b0;
      samples.opcode <= OP_ADD;
      samples.sample_value <= '0;
    end else if (!samples.valid || took) begin
      if (gap_left > 0) begin
        gap_left--;
        samples.valid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        sample_word_t it;
        it = pend_q.pop_front();
        samples.opcode <= it.opcode;
        samples.sample_value <= it.sample_value;
        samples.valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        samples.valid <= 1'b0;
      end
    end
  end

  // receiver: changing stall mode, plus one long hold-off while words keep coming
  int mode = 0, mode_left = 0, hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      if (!hold_done && results.valid && pend_q.size() > 0) begin
        hold_done = 1'b1;
        hold_left = 3000;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        results.ready <= 1'b0;
      end else begin
        case (mode)
          0: results.ready <= 1'b1;
          1: results.ready <= 1'($urandom_range(0, 1));
          default: results.ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // monitor: predict on accepted samples, compare accepted results
  always @(posedge clk) begin
    took <= samples.valid && samples.ready;
    if (!rst && samples.valid && samples.ready) begin
      if (samples.opcode == OP_FINISH) emit_free_energy();
      else bin_sample(samples.sample_value);
    end
    if (!rst && results.valid && results.ready) begin
      bin_word_t want;
      n_bins++;
      if (bins_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, got center %h energy %h last %b miss %b", $time,
                 results.bin_center, results.free_energy, results.last, results.range_miss);
      end else begin
        want = bins_q.pop_front();
        if (results.bin_center !== want.bin_center) begin
          errors++;
          $display("%0t: bin_center expected %h got %h", $time, want.bin_center,
                   results.bin_center);
        end
        if (results.free_energy !== want.free_energy) begin
          errors++;
          $display("%0t: free_energy expected %h got %h", $time, want.free_energy,
                   results.free_energy);
        end
        if (results.last !== want.last) begin
          errors++;
          $display("%0t: last expected %b got %b", $time, want.last, results.last);
        end
        if (results.range_miss !== want.range_miss) begin
          errors++;
          $display("%0t: range_miss expected %b got %b", $time, want.range_miss,
                   results.range_miss);
        end
      end
    end
  end

  task automatic push_word(input logic op, input logic [31:0] v);
    sample_word_t it;
    it.opcode = op;
    it.sample_value = v;
    pend_q = {pend_q, it};
  endtask

  // wait for the block to drain, then let a finish scan run out
  task automatic settle();
    while (pend_q.size() != 0 || samples.valid || bins_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    case (idx)
      REG_BIN_WIDTH:   width_reg = 64'(val[30:0]);
      REG_TEMPERATURE: temp_reg = 64'(val[30:0]);
      REG_SPRING:      spring_reg = 64'(val[30:0]);
      REG_BIAS_CENTER: center_reg = longint'(signed'(val));
      REG_LOWEST_BIN:  low_bin_reg = longint'(signed'(val[15:0]));
      default: ;
    endcase
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic configure(input logic [31:0] w, t, k, x0, lb);
    write_reg(REG_BIN_WIDTH, w);
    write_reg(REG_TEMPERATURE, t);
    write_reg(REG_SPRING, k);
    write_reg(REG_BIAS_CENTER, x0);
    write_reg(REG_LOWEST_BIN, lb);
  endtask

  // mostly samples aimed into a few window slots, some noise, then a finish
  task automatic random_batch(input int n);
    longint w, y;
    int hot;
    w = eff_width();
    hot = $urandom_range(0, 63);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 6) == 0) begin
        push_word(OP_ADD, $urandom);
      end else begin
        int s;
        s = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 63)
                                        : (hot + $urandom_range(0, 3)) % 64;
        y = (low_bin_reg + s) * w + longint'($urandom_range(0, 32'(w - 1)));
        push_word(OP_ADD, y[31:0]);
      end
    end
    push_word(OP_FINISH, $urandom);
  endtask

  initial begin
    logic [31:0] wv, tv, kv, xv, lv;
    width_reg = 65536;
    temp_reg = 65536;
    spring_reg = 0;
    center_reg = 0;
    low_bin_reg = -32;
    hist_total = 0;
    miss_seen = 1'b0;
    foreach (hist[i]) hist[i] = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, window edges, empty finish
    push_word(OP_FINISH, 32'h0);
    push_word(OP_ADD, 32'h0000_0000);
    push_word(OP_ADD, 32'hFFFF_FFFF);
    push_word(OP_ADD, 32'hFFE0_0000);
    push_word(OP_ADD, 32'h001F_FFFF);
    push_word(OP_ADD, 32'h0020_0000);
    push_word(OP_ADD, 32'h7FFF_FFFF);
    push_word(OP_ADD, 32'h8000_0000);
    push_word(OP_ADD, 32'h0000_0000);
    push_word(OP_FINISH, 32'hFFFF_FFFF);
    // queued behind the finish so the input backs up while results stall
    for (int i = 0; i < 24; i++) push_word(OP_ADD, 32'(i << 16));
    push_word(OP_FINISH, 32'h0);
    settle();
    // zero width acts as one LSB; full-scale bias and temperature
    configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000);
    push_word(OP_ADD, 32'hFFFF_8000);
    push_word(OP_ADD, 32'hFFFF_803F);
    push_word(OP_ADD, 32'hFFFF_7FFF);
    push_word(OP_FINISH, 32'h0);
    settle();
    configure(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    push_word(OP_ADD, 32'h7FFF_FFFF);
    push_word(OP_ADD, 32'h8000_0000);
    push_word(OP_ADD, 32'h0000_0001);
    push_word(OP_FINISH, 32'h0);
    settle();
    configure(32'h1, 32'h10000, 32'h100, 32'h0, 32'h7FFF);
    push_word(OP_ADD, 32'h0000_7FFF);
    push_word(OP_ADD, 32'h0000_803E);
    push_word(OP_FINISH, 32'h0);
    settle();

    for (int ph = 0; ph < 11; ph++) begin
      case ($urandom_range(0, 3))
        0: wv = $urandom_range(1, 32'h0004_0000);
        1: wv = $urandom_range(1, 64);
        2: wv = $urandom;
        default: wv = 32'h0001_0000;
      endcase
      tv = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000);
      kv = ($urandom_range(0, 2) == 0) ? 32'h0 : $urandom_range(0, 32'h0002_0000);
      if ($urandom_range(0, 5) == 0) kv = $urandom;
      xv = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 32'h0040_0000);
      lv = ($urandom_range(0, 1) == 0) ? $urandom
                                       : 32'(-$urandom_range(0, 64) + $urandom_range(0, 32));
      configure(wv, tv, kv, xv, lv);
      random_batch($urandom_range(25, 45));
      if (ph == 5) random_batch($urandom_range(10, 20));
      settle();
    end

    $display("covered %0d samples (%0d outside the window) and %0d finishes,", n_adds,
             n_outside, n_finish);
    $display("checked %0d bin words across 15 register settings", n_bins);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d words still expected", bins_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
